@@ rtl/bdq_pkg.sv @@
// ============================================================================
// bdq_pkg
// Shared types and constants for the bounded double-ended queue.
// ============================================================================
package bdq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned POS_W     = 5;

  // Request opcodes. Codes 6 and 7 are unused and are dropped silently.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_LIST       = 3'd4,
    OP_CLEAR      = 3'd5
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Pointer update commands from the sequencer to the ring pointer unit.
  typedef struct packed {
    logic add_front;
    logic add_back;
    logic take_front;
    logic take_back;
    logic clear;
  } ptr_cmd_t;

  // Occupancy flags from the ring pointer unit.
  typedef struct packed {
    logic full;
    logic empty;
  } ptr_stat_t;

endpackage

@@ rtl/bounded_deque.sv @@
// ============================================================================
// bounded_deque
// Bounded double-ended queue of signed 16-bit values kept in a ring buffer.
// ============================================================================
//
// Channel    Direction  Handshake                 Payload
// request    in         start_i, busy_o           opcode_i, value_i
// result     out        valid_o (one-cycle pulse) status_o, element_o,
//                                                 position_o, last_o
//
// The result of a push, pop or clear appears in the cycle after the
// request, and a new request may be given in that same cycle.
// A listing of N entries gives N results on consecutive cycles, one memory
// read per entry, and holds busy_o high on every result but the last.
// Each memory access is a single read or write per cycle, and no read is
// issued in the same cycle as a write, so no forwarding is needed. Reset
// clears the head and the count; entry contents are not cleared. The
// receiver cannot stall: every result pulse must be taken.
//
module bounded_deque #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [bdq_pkg::OP_W-1:0]          opcode_i,
  input  logic signed [bdq_pkg::VAL_W-1:0]  value_i,
  output logic                              busy_o,
  output logic                              valid_o,
  output logic [bdq_pkg::ST_W-1:0]          status_o,
  output logic signed [bdq_pkg::VAL_W-1:0]  element_o,
  output logic [bdq_pkg::POS_W-1:0]         position_o,
  output logic                              last_o
);

  import bdq_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ptr_cmd_t                ptr_cmd;
  ptr_stat_t               ptr_stat;
  logic [IDX_W-1:0]        head;
  logic [CNT_W-1:0]        count;
  logic [IDX_W-1:0]        front_push_slot;
  logic [IDX_W-1:0]        back_push_slot;
  logic [IDX_W-1:0]        back_pop_slot;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic                    mem_re;
  logic [IDX_W-1:0]        mem_raddr;
  logic signed [VAL_W-1:0] mem_rdata;

  // The head and the count live in the pointer unit, which does the slot
  // arithmetic for pushes and pops; the sequencer wraps its listing pointer.
  bdq_ptr #(
    .DEPTH (DEPTH)
  ) u_ptr (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (ptr_cmd),
    .stat_o            (ptr_stat),
    .head_o            (head),
    .count_o           (count),
    .front_push_slot_o (front_push_slot),
    .back_push_slot_o  (back_push_slot),
    .back_pop_slot_o   (back_pop_slot)
  );

  // The sequencer decodes each request, reads or writes the slot that a push
  // or pop needs, and steps through the ring during a listing.
  bdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .opcode_i          (opcode_i),
    .value_i           (value_i),
    .busy_o            (busy_o),
    .valid_o           (valid_o),
    .status_o          (status_o),
    .element_o         (element_o),
    .position_o        (position_o),
    .last_o            (last_o),
    .cmd_o             (ptr_cmd),
    .stat_i            (ptr_stat),
    .head_i            (head),
    .count_i           (count),
    .front_push_slot_i (front_push_slot),
    .back_push_slot_i  (back_push_slot),
    .back_pop_slot_i   (back_pop_slot),
    .we_o              (mem_we),
    .waddr_o           (mem_waddr),
    .wdata_o           (mem_wdata),
    .re_o              (mem_re),
    .raddr_o           (mem_raddr),
    .rdata_i           (mem_rdata)
  );

  // Entry storage with a registered read.
  bdq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (VAL_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Busy is only raised while a listing is still producing results.
  a_busy_has_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (valid_o && !last_o)
  ) else $error("busy without a listing result in flight");

  // A listing of a non-empty queue starts with the front entry at position 1.
  a_list_first_pos : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (opcode_i == OP_LIST) && (count != '0))
      |=> (valid_o && (position_o == POS_W'(1)) && (status_o == ST_OK))
  ) else $error("listing did not start at position 1");

  // A push that fits grows the count by exactly one.
  a_push_grows : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && ((opcode_i == OP_PUSH_FRONT) || (opcode_i == OP_PUSH_BACK))
      && (count != CNT_W'(DEPTH)))
      |=> (count == CNT_W'($past(count) + 1'b1))
  ) else $error("successful push did not grow the count");

  // The queue is never touched mid-list, so the count holds still.
  a_count_hold_in_list : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> $stable(count)
  ) else $error("count changed during a listing");

endmodule

@@ rtl/bdq_mem.sv @@
// ============================================================================
// bdq_mem
// Entry storage: one write port and one read port, registered read data.
// ============================================================================
module bdq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 16,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [IDX_W-1:0]        waddr_i,
  input  logic signed [WIDTH-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [IDX_W-1:0]        raddr_i,
  output logic signed [WIDTH-1:0] rdata_o
);

  logic signed [WIDTH-1:0] mem [DEPTH];
  logic signed [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bdq_ptr.sv @@
// ============================================================================
// bdq_ptr
// Ring pointer unit: head slot, entry count and the slots derived from them.
// ============================================================================
module bdq_ptr #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bdq_pkg::ptr_cmd_t   cmd_i,
  output bdq_pkg::ptr_stat_t  stat_o,
  output logic [IDX_W-1:0]    head_o,
  output logic [CNT_W-1:0]    count_o,
  output logic [IDX_W-1:0]    front_push_slot_o,
  output logic [IDX_W-1:0]    back_push_slot_o,
  output logic [IDX_W-1:0]    back_pop_slot_o
);

  import bdq_pkg::*;

  localparam int unsigned SUM_W = CNT_W + 1;

  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] sum_push, sum_pop;
  logic [IDX_W-1:0] head_inc, head_dec;

  assign head_inc = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
  assign head_dec = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);

  // head + count stays below twice the depth, so one subtract wraps it.
  assign sum_push = SUM_W'(head_q) + SUM_W'(count_q);
  assign sum_pop  = sum_push - SUM_W'(1);

  always_comb begin
    front_push_slot_o = head_dec;
    back_push_slot_o  = (sum_push >= SUM_W'(DEPTH)) ? IDX_W'(sum_push - SUM_W'(DEPTH))
                                                    : IDX_W'(sum_push);
    back_pop_slot_o   = (sum_pop >= SUM_W'(DEPTH)) ? IDX_W'(sum_pop - SUM_W'(DEPTH))
                                                   : IDX_W'(sum_pop);
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    priority if (cmd_i.clear) begin
      head_d  = '0;
      count_d = '0;
    end else if (cmd_i.add_front) begin
      head_d  = head_dec;
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.add_back) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.take_front) begin
      head_d  = head_inc;
      count_d = count_q - CNT_W'(1);
    end else if (cmd_i.take_back) begin
      count_d = count_q - CNT_W'(1);
    end else begin
      head_d  = head_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = head_q;
  assign count_o      = count_q;

endmodule

@@ rtl/bdq_ctrl.sv @@
// ============================================================================
// bdq_ctrl
// Request sequencer: decodes opcodes, drives the entry memory and pointer
// unit, walks the ring for a listing and registers the result fields.
// ============================================================================
module bdq_ctrl #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [bdq_pkg::OP_W-1:0]          opcode_i,
  input  logic signed [bdq_pkg::VAL_W-1:0]  value_i,
  output logic                              busy_o,
  output logic                              valid_o,
  output logic [bdq_pkg::ST_W-1:0]          status_o,
  output logic signed [bdq_pkg::VAL_W-1:0]  element_o,
  output logic [bdq_pkg::POS_W-1:0]         position_o,
  output logic                              last_o,
  output bdq_pkg::ptr_cmd_t                 cmd_o,
  input  bdq_pkg::ptr_stat_t                stat_i,
  input  logic [IDX_W-1:0]                  head_i,
  input  logic [CNT_W-1:0]                  count_i,
  input  logic [IDX_W-1:0]                  front_push_slot_i,
  input  logic [IDX_W-1:0]                  back_push_slot_i,
  input  logic [IDX_W-1:0]                  back_pop_slot_i,
  output logic                              we_o,
  output logic [IDX_W-1:0]                  waddr_o,
  output logic signed [bdq_pkg::VAL_W-1:0]  wdata_o,
  output logic                              re_o,
  output logic [IDX_W-1:0]                  raddr_o,
  input  logic signed [bdq_pkg::VAL_W-1:0]  rdata_i
);

  import bdq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e;

  state_e                  state_q, state_d;
  logic                    valid_q, valid_d;
  logic                    last_q, last_d;
  logic                    from_mem_q, from_mem_d;
  status_e                 status_q, status_d;
  logic signed [VAL_W-1:0] elem_q, elem_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic [IDX_W-1:0]        ptr_q, ptr_d;
  logic [CNT_W-1:0]        idx_inc;
  logic [IDX_W-1:0]        ptr_inc, head_inc;
  logic [31:0]             idx_wide;
  op_e                     op;
  logic                    listing;

  assign op       = op_e'(opcode_i);
  assign listing  = (state_q == S_LIST) && !last_q;
  assign idx_inc  = idx_q + CNT_W'(1);
  assign ptr_inc  = (ptr_q == IDX_W'(DEPTH - 1)) ? '0 : ptr_q + IDX_W'(1);
  assign head_inc = (head_i == IDX_W'(DEPTH - 1)) ? '0 : head_i + IDX_W'(1);

  always_comb begin
    state_d    = state_q;
    valid_d    = 1'b0;
    last_d     = 1'b1;
    from_mem_d = 1'b0;
    status_d   = ST_OK;
    elem_d     = '0;
    idx_d      = '0;
    ptr_d      = ptr_q;
    cmd_o      = '0;
    we_o       = 1'b0;
    waddr_o    = back_push_slot_i;
    wdata_o    = value_i;
    re_o       = 1'b0;
    raddr_o    = ptr_q;

    if (listing) begin
      // Present the entry read last cycle and fetch the next one.
      re_o       = 1'b1;
      ptr_d      = ptr_inc;
      idx_d      = idx_inc;
      last_d     = (idx_inc == count_i);
      valid_d    = 1'b1;
      from_mem_d = 1'b1;
    end else begin
      state_d = S_IDLE;
      if (start_i) begin
        unique case (op)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            valid_d = 1'b1;
            elem_d  = value_i;
            if (stat_i.full) begin
              status_d = ST_FULL;
            end else begin
              we_o            = 1'b1;
              waddr_o         = (op == OP_PUSH_FRONT) ? front_push_slot_i
                                                      : back_push_slot_i;
              cmd_o.add_front = (op == OP_PUSH_FRONT);
              cmd_o.add_back  = (op == OP_PUSH_BACK);
            end
          end
          OP_POP_FRONT, OP_POP_BACK: begin
            valid_d = 1'b1;
            if (stat_i.empty) begin
              status_d = ST_EMPTY;
            end else begin
              re_o             = 1'b1;
              raddr_o          = (op == OP_POP_FRONT) ? head_i : back_pop_slot_i;
              cmd_o.take_front = (op == OP_POP_FRONT);
              cmd_o.take_back  = (op == OP_POP_BACK);
              from_mem_d       = 1'b1;
            end
          end
          OP_LIST: begin
            valid_d = 1'b1;
            if (stat_i.empty) begin
              status_d = ST_EMPTY;
            end else begin
              re_o       = 1'b1;
              raddr_o    = head_i;
              ptr_d      = head_inc;
              idx_d      = CNT_W'(1);
              last_d     = (count_i == CNT_W'(1));
              from_mem_d = 1'b1;
              state_d    = S_LIST;
            end
          end
          OP_CLEAR: begin
            valid_d     = 1'b1;
            cmd_o.clear = 1'b1;
          end
          default: begin
            valid_d = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= 1'b0;
      last_q     <= 1'b1;
      from_mem_q <= 1'b0;
      status_q   <= ST_OK;
      elem_q     <= '0;
      idx_q      <= '0;
      ptr_q      <= '0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      last_q     <= last_d;
      from_mem_q <= from_mem_d;
      status_q   <= status_d;
      elem_q     <= elem_d;
      idx_q      <= idx_d;
      ptr_q      <= ptr_d;
    end
  end

  // Positions wrap to the width of the result field for very deep queues.
  assign idx_wide   = 32'(idx_q);
  assign position_o = idx_wide[POS_W-1:0];
  assign busy_o     = listing;
  assign valid_o    = valid_q;
  assign status_o   = status_q;
  assign element_o  = from_mem_q ? rdata_i : elem_q;
  assign last_o     = last_q;

endmodule

@@ dv/bounded_deque_tb.sv @@
// ============================================================================
// bounded_deque_tb
// Self-checking testbench for the bounded double-ended queue. A directed
// part covers the empty and full corners, the value extremes and every
// opcode, including the unused ones. Random traffic then swings the fill
// level between empty and full. A local model predicts every result, and
// a monitor compares each result strobe against the oldest prediction.
// ============================================================================
module bounded_deque_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 120;
  // The final stretch of random traffic runs back to back, with no gaps.
  localparam int unsigned NO_IDLE_TAIL = 30;

  // The two opcodes outside the defined set; the block must ignore them.
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  // One predicted result, in the same shape as the result ports.
  typedef struct {
    status_e                   status;
    logic signed [VAL_W-1:0]   element;
    logic [POS_W-1:0]          position;
    logic                      last;
  } result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start_i;
  logic [OP_W-1:0]           opcode_i;
  logic signed [VAL_W-1:0]   value_i;
  logic                      busy_o;
  logic                      valid_o;
  logic [ST_W-1:0]           status_o;
  logic signed [VAL_W-1:0]   element_o;
  logic [POS_W-1:0]          position_o;
  logic                      last_o;

  // Local copy of the deque contents, used to predict results.
  logic signed [VAL_W-1:0]   deque_mem [DEPTH];
  int unsigned               deque_head;
  int unsigned               deque_count;

  // Predicted results that the block has not produced yet, oldest first.
  result_t                   expected_results [$];

  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned push_reqs, pop_reqs, list_reqs, clear_reqs, ignored_reqs;
  int unsigned full_rejects, empty_rejects;
  int unsigned peak_fill;

  bounded_deque #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .opcode_i  (opcode_i),
    .value_i   (value_i),
    .busy_o    (busy_o),
    .valid_o   (valid_o),
    .status_o  (status_o),
    .element_o (element_o),
    .position_o(position_o),
    .last_o    (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs or stops producing results.
  initial begin
    #200us;
    $display("TEST FAILED");
    $finish;
  end

  // Works out what the block must return for one accepted request and
  // updates the local copy of the deque. Pushes, pops and clears give a single
  // result; a listing gives one result per stored entry, front to back, or one
  // empty report. Codes outside the opcode set give nothing and change nothing.
  function automatic void predict_request(input logic [OP_W-1:0] op,
                                          input logic signed [VAL_W-1:0] val);
    result_t     r;
    int unsigned slot;
    r = '{status: ST_OK, element: '0, position: '0, last: 1'b1};
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        push_reqs++;
        r.element = val;
        if (deque_count == DEPTH) begin
          // A push into a full deque echoes the value and stores nothing.
          r.status = ST_FULL;
          full_rejects++;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            deque_head = (deque_head + DEPTH - 1) % DEPTH;
            slot = deque_head;
          end else begin
            slot = (deque_head + deque_count) % DEPTH;
          end
          deque_mem[slot] = val;
          deque_count++;
          if (deque_count > peak_fill) peak_fill = deque_count;
        end
        expected_results = {expected_results, r};
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        pop_reqs++;
        if (deque_count == 0) begin
          r.status = ST_EMPTY;
          empty_rejects++;
        end else begin
          if (op == OP_POP_FRONT) begin
            slot = deque_head;
            deque_head = (deque_head + 1) % DEPTH;
          end else begin
            slot = (deque_head + deque_count - 1) % DEPTH;
          end
          deque_count--;
          r.element = deque_mem[slot];
        end
        expected_results = {expected_results, r};
      end
      OP_LIST: begin
        list_reqs++;
        if (deque_count == 0) begin
          r.status = ST_EMPTY;
          empty_rejects++;
          expected_results = {expected_results, r};
        end else begin
          for (int unsigned k = 0; k < deque_count; k++) begin
            r.element  = deque_mem[(deque_head + k) % DEPTH];
            r.position = POS_W'(k + 1);
            r.last     = (k + 1 == deque_count);
            expected_results = {expected_results, r};
          end
        end
      end
      OP_CLEAR: begin
        // Only the head and the count go back to zero; contents stay.
        clear_reqs++;
        deque_head  = 0;
        deque_count = 0;
        expected_results = {expected_results, r};
      end
      default: begin
        ignored_reqs++;
      end
    endcase
  endfunction

  // Mostly uniform values, with the signed extremes, zero and minus one
  // showing up often enough to matter.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return VAL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Presents one request and holds it until the block takes it. The
  // request is taken at the first rising edge where busy_o is low; start_i
  // is left high so that a following request can go out back to back.
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [VAL_W-1:0] val);
    start_i  <= 1'b1;
    opcode_i <= op;
    value_i  <= val;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_request(op, val);
  endtask

  // Drops start_i for a number of cycles and scrambles the payload
  // meanwhile; the block must ignore it.
  task automatic idle_for(input int unsigned cycles);
    start_i  <= 1'b0;
    opcode_i <= OP_W'($urandom);
    value_i  <= VAL_W'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  // Pops and listings on an empty deque, plus the two unused codes.
  task automatic test_empty_deque();
    send_request(OP_POP_FRONT, 16'sh1234);
    send_request(OP_POP_BACK, -16'sd1);
    send_request(OP_LIST, 16'sh0000);
    send_request(OP_SPARE_A, 16'sh7FFF);
    send_request(OP_SPARE_B, 16'sh8000);
  endtask

  // Fills the deque from both ends with the value extremes first, then
  // pushes at both ends while full and lists all sixteen entries.
  task automatic test_fill_and_overflow();
    logic signed [VAL_W-1:0] val;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      case (i)
        0:       val = 16'sh7FFF;
        1:       val = 16'sh8000;
        2:       val = 16'sh0000;
        3:       val = -16'sd1;
        default: val = pick_value();
      endcase
      send_request(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, val);
    end
    send_request(OP_PUSH_FRONT, 16'sh5A5A);
    send_request(OP_PUSH_BACK, -16'sh5A5A);
    send_request(OP_LIST, 16'sh0000);
  endtask

  // Takes one entry from each end, then clears and lists the empty deque.
  task automatic test_drain_and_clear();
    send_request(OP_POP_FRONT, 16'sh0000);
    send_request(OP_POP_BACK, 16'sh0000);
    send_request(OP_CLEAR, 16'sh7FFF);
    send_request(OP_LIST, 16'sh0000);
  endtask

  // Random traffic that alternates between filling and draining, so that
  // the fill level keeps sweeping the whole range and both the full and
  // the empty corner are hit repeatedly. The mode flips only some of the
  // time once a corner is reached, which lets a few rejected pushes and
  // pops through. Clears, listings and unused codes are mixed in.
  task automatic test_random_traffic();
    int unsigned      counted;
    int unsigned      roll;
    bit               filling;
    logic [OP_W-1:0]  op;
    counted = 0;
    filling = 1'b1;
    while (counted < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        op = $urandom_range(0, 1) ? OP_SPARE_B : OP_SPARE_A;
      end else if (roll < 5) begin
        op = OP_CLEAR;
      end else if (roll < 13) begin
        op = OP_LIST;
      end else if (roll < (filling ? 80 : 35)) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      end

      // Gaps in random bursts, except in the closing stretch.
      if (counted < RANDOM_ITEMS - NO_IDLE_TAIL && $urandom_range(0, 3) == 0) begin
        idle_for($urandom_range(1, 11));
      end

      send_request(op, pick_value());
      if (op != OP_SPARE_A && op != OP_SPARE_B) counted++;

      if (deque_count == DEPTH && $urandom_range(0, 1)) filling = 1'b0;
      if (deque_count == 0 && $urandom_range(0, 1)) filling = 1'b1;
    end
  endtask

  // Every result strobe is taken at the edge that ends its cycle and is
  // matched against the oldest prediction still waiting.
  always @(posedge clk_i) begin : check_results
    result_t exp_r;
    if (rst_ni === 1'b1 && valid_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d element %0d position %0d last %0b",
               status_o, element_o, position_o, last_o);
        mismatches++;
      end else begin
        exp_r = expected_results[0];
        expected_results.delete(0);
        results_checked++;
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          mismatches++;
        end
        if (element_o !== exp_r.element) begin
          $error("element: expected %0d, got %0d", exp_r.element, element_o);
          mismatches++;
        end
        if (position_o !== exp_r.position) begin
          $error("position: expected %0d, got %0d", exp_r.position, position_o);
          mismatches++;
        end
        if (last_o !== exp_r.last) begin
          $error("last: expected %0b, got %0b", exp_r.last, last_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    opcode_i    = OP_CLEAR;
    value_i     = '0;
    deque_head  = 0;
    deque_count = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_deque();
    test_fill_and_overflow();
    test_drain_and_clear();
    test_random_traffic();
    start_i <= 1'b0;

    // A full listing is the longest tail; idle past one at the end.
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 4) @(posedge clk_i);

    $display("Sent %0d pushes, %0d pops, %0d listings, %0d clears and %0d unused codes.",
             push_reqs, pop_reqs, list_reqs, clear_reqs, ignored_reqs);
    $display("Checked %0d results: %0d full rejects, %0d empty reports, peak fill %0d of %0d.",
             results_checked, full_rejects, empty_rejects, peak_fill, DEPTH);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bdq_pkg.sv
rtl/bdq_mem.sv
rtl/bdq_ptr.sv
rtl/bdq_ctrl.sv
rtl/bounded_deque.sv
dv/bounded_deque_tb.sv
